/* design/nimt_pkg.sv */
// Package for the node ID map table: the table size, entry and control types, and codes.
// It depends on nothing else. Every other design file uses it by scoped names.

package nimt_pkg;

	// Number of table entries. Legal values run from 2 to 64.
	localparam int ENTRIES = 32;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int UID_W   = 32;
	localparam int NUM_W   = 8;

	// Command codes of a request.
	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_ALLOC  = 2'd3
	} cmd_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PASS1,
		ST_PASS2,
		ST_FINISH
	} state_t;

	// One table entry. A unique ID of zero marks the entry as empty.
	typedef struct packed {
		logic [UID_W-1:0] uid;
		logic [NUM_W-1:0] num;
	} entry_t;

	// Control that the sequencer sends to every cell of the ring.
	typedef struct packed {
		logic shift;
		logic clear;
	} ring_ctl_t;

endpackage

/* design/nimt_cell.sv */
// One cell of the entry ring: holds a single table entry.
// It takes the entry of its neighbour on each shift. Uses nimt_pkg.

module nimt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  nimt_pkg::ring_ctl_t ctl,
	input  nimt_pkg::entry_t   nxt,
	output nimt_pkg::entry_t   cur
);

	nimt_pkg::entry_t ent_q;

	// Entry register: cleared by reset or a clear request, loaded on each shift.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (ctl.clear) begin
			ent_q <= '0;
		end else if (ctl.shift) begin
			ent_q <= nxt;
		end
	end

	assign cur = ent_q;

endmodule

/* design/nimt_ctrl.sv */
// Sequencer and head unit of the node ID map table.
// It rotates the entry ring once or twice per insert, query or allocate, inspects and
// rewrites the entry at the head, and holds the result register. Uses nimt_pkg.

module nimt_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [7:0]                cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                cmd,
	input  logic [31:0]               unique_id,
	input  logic [7:0]                node_number,
	input  nimt_pkg::entry_t          head,
	output nimt_pkg::entry_t          tail,
	output nimt_pkg::ring_ctl_t       ring,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      stored,
	output logic                      is_valid_remote,
	output logic [7:0]                free_number
);

	localparam logic [nimt_pkg::IDX_W-1:0] LAST_IDX = nimt_pkg::IDX_W'(nimt_pkg::ENTRIES - 1);
	localparam logic [nimt_pkg::NUM_W-1:0] NUM_LIMIT = nimt_pkg::NUM_W'(nimt_pkg::ENTRIES);

	nimt_pkg::state_t                state_q, state_d;
	nimt_pkg::cmd_t                  cmd_q;
	logic [nimt_pkg::UID_W-1:0]      uid_q;
	logic [nimt_pkg::NUM_W-1:0]      num_q;
	logic [nimt_pkg::NUM_W-1:0]      own_q;
	logic [nimt_pkg::IDX_W-1:0]      cnt_q, cnt_d;
	logic                            done_q, done_d;
	logic                            hit_q, hit_d;
	logic [nimt_pkg::ENTRIES-1:0]    held_q, held_d;
	logic                            accept;
	logic                            load_out;
	logic [nimt_pkg::ENTRIES-1:0]    free_v;
	logic                            out_valid_q;
	logic                            stored_q;
	logic                            valid_q;
	logic [7:0]                      free_q;

	// Index of the lowest set bit: isolate it, then encode the one-hot word.
	function automatic logic [nimt_pkg::IDX_W-1:0] lowest_set(
		input logic [nimt_pkg::ENTRIES-1:0] v
	);
		logic [nimt_pkg::ENTRIES-1:0] oh;
		logic [nimt_pkg::IDX_W-1:0]   idx;
		oh  = v & (~v + nimt_pkg::ENTRIES'(1));
		idx = '0;
		for (int i = 0; i < nimt_pkg::ENTRIES; i++) begin
			if (oh[i]) begin
				idx = idx | nimt_pkg::IDX_W'(i);
			end
		end
		return idx;
	endfunction

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == nimt_pkg::ST_IDLE);

	// Numbers that are free for allocation: not held, not zero and not our own.
	always_comb begin
		free_v    = ~held_q;
		free_v[0] = 1'b0;
		if (own_q < NUM_LIMIT) begin
			free_v[own_q[nimt_pkg::IDX_W-1:0]] = 1'b0;
		end
	end

	// Next state, head rewrite and ring control.
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		done_d     = done_q;
		hit_d      = hit_q;
		held_d     = held_q;
		tail       = head;
		ring.shift = 1'b0;
		ring.clear = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			nimt_pkg::ST_IDLE: begin
				if (accept) begin
					cnt_d  = '0;
					done_d = 1'b0;
					hit_d  = 1'b0;
					held_d = '0;
					if (nimt_pkg::cmd_t'(cmd) == nimt_pkg::CMD_CLEAR) begin
						ring.clear = 1'b1;
						state_d    = nimt_pkg::ST_FINISH;
					end else begin
						state_d = nimt_pkg::ST_PASS1;
					end
				end
			end
			nimt_pkg::ST_PASS1: begin
				// First rotation: update the first matching entry and gather held numbers.
				ring.shift = 1'b1;
				cnt_d      = cnt_q + 1'b1;
				if (head.num == num_q) begin
					hit_d = 1'b1;
				end
				if (head.num < NUM_LIMIT) begin
					held_d[head.num[nimt_pkg::IDX_W-1:0]] = 1'b1;
				end
				if (cmd_q == nimt_pkg::CMD_INSERT && !done_q && head.uid == uid_q) begin
					tail.num = num_q;
					done_d   = 1'b1;
				end
				if (cnt_q == LAST_IDX) begin
					cnt_d = '0;
					if (cmd_q == nimt_pkg::CMD_INSERT && !done_d) begin
						state_d = nimt_pkg::ST_PASS2;
					end else begin
						state_d = nimt_pkg::ST_FINISH;
					end
				end
			end
			nimt_pkg::ST_PASS2: begin
				// Second rotation: no match was found, so fill the first empty entry.
				ring.shift = 1'b1;
				cnt_d      = cnt_q + 1'b1;
				if (!done_q && head.uid == '0) begin
					tail.uid = uid_q;
					tail.num = num_q;
					done_d   = 1'b1;
				end
				if (cnt_q == LAST_IDX) begin
					cnt_d   = '0;
					state_d = nimt_pkg::ST_FINISH;
				end
			end
			nimt_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = nimt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = nimt_pkg::ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nimt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Scan counter and the flags gathered during a rotation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
			hit_q  <= 1'b0;
			held_q <= '0;
		end else begin
			cnt_q  <= cnt_d;
			done_q <= done_d;
			hit_q  <= hit_d;
			held_q <= held_d;
		end
	end

	// Request fields, captured when the request is accepted.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= nimt_pkg::cmd_t'(cmd);
			uid_q <= unique_id;
			num_q <= node_number;
		end
	end

	// Own node number register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q <= '0;
		end else if (cfg_wr_en) begin
			own_q <= cfg_wr_data;
		end
	end

	// Result register: the result waits here while the next request is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Each field is zero unless it belongs to the command, so a clear gives all zeros.
	always_ff @(posedge clk) begin
		if (load_out) begin
			stored_q <= (cmd_q == nimt_pkg::CMD_INSERT) && done_q;
			valid_q  <= (cmd_q == nimt_pkg::CMD_QUERY) && hit_q && (num_q != '0) &&
				(num_q != own_q);
			if (cmd_q == nimt_pkg::CMD_ALLOC && free_v != '0) begin
				free_q <= 8'(lowest_set(free_v));
			end else begin
				free_q <= '0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign stored          = stored_q;
	assign is_valid_remote = valid_q;
	assign free_number     = free_q;

	// A clear and a shift of the ring never coincide.
	a_clear_shift: assert property (@(posedge clk) disable iff (!arst_n)
		!(ring.clear && ring.shift))
		else $error("Ring cleared and shifted in the same cycle.");

	// A new result only appears after the finishing state.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == nimt_pkg::ST_FINISH))
		else $error("Result raised outside the finishing state.");

	// At most one result field is ever active.
	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot0({stored_q, valid_q, free_q != '0}))
		else $error("More than one result field active.");

	// An allocated number lies below the table size and is not our own.
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && free_q != '0) |-> (free_q < NUM_LIMIT && free_q != own_q))
		else $error("Allocated number out of range or equal to own number.");

	// Every rotation ends with the counter back at the start.
	a_rot_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nimt_pkg::ST_FINISH) |-> (cnt_q == '0))
		else $error("Ring rotation left incomplete.");

endmodule

/* design/node_id_map_table.sv */
// Node ID map table: a table of ENTRIES remote nodes, each a 32-bit unique ID and an 8-bit
// node number, held in a ring of cells that rotates past one head unit. Requests are taken
// one at a time. A clear empties every cell without turning the ring; a query or an allocate
// takes one full turn of the ring; an insert takes one turn when the unique ID is found and
// a second turn when it is not, to fill an empty entry. The ring turns one entry per cycle
// past the head. A finished result waits in an output register while the next request is
// taken. The user must write the own node number through cfg_wr_en and cfg_wr_data only
// while no request is in progress; the block itself does not enforce this.
// Uses nimt_pkg, nimt_cell and nimt_ctrl.

module node_id_map_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [31:0] unique_id,
	input  logic [7:0]  node_number,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        stored,
	output logic        is_valid_remote,
	output logic [7:0]  free_number
);

	nimt_pkg::entry_t    ring_ent [nimt_pkg::ENTRIES];
	nimt_pkg::entry_t    tail;
	nimt_pkg::ring_ctl_t ring_ctl;

	// Sequencer and head unit.
	nimt_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cmd             (cmd),
		.unique_id       (unique_id),
		.node_number     (node_number),
		.head            (ring_ent[0]),
		.tail            (tail),
		.ring            (ring_ctl),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.stored          (stored),
		.is_valid_remote (is_valid_remote),
		.free_number     (free_number)
	);

	// Ring of entry cells: each takes its upper neighbour, the last one takes the head output.
	for (genvar i = 0; i < nimt_pkg::ENTRIES; i++) begin : g_cell
		if (i == nimt_pkg::ENTRIES - 1) begin : g_last
			nimt_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ring_ctl),
				.nxt    (tail),
				.cur    (ring_ent[i])
			);
		end else begin : g_mid
			nimt_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ring_ctl),
				.nxt    (ring_ent[i+1]),
				.cur    (ring_ent[i])
			);
		end
	end

endmodule

/* dv/node_id_map_table_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for node_id_map_table: a directed table of requests, then
// random table-fill sequences and noise, checked against a shadow copy of the node table.
// Depends on nimt_pkg and the node_id_map_table RTL only.

module node_id_map_table_test;

	localparam int CYCLE_LIMIT = 800000;
	localparam int PHASE_COUNT = 6;

	// One reply of the table: only the field of the request's command can be nonzero.
	typedef struct {
		logic       stored;
		logic       valid_remote;
		logic [7:0] free_num;
	} table_reply_t;

	// One request, with an optional reply written out by hand.
	typedef struct {
		nimt_pkg::cmd_t op;
		logic [31:0]    id;
		logic [7:0]     num;
		bit             typed;
		table_reply_t   want;
	} table_request_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [7:0]  cfg_wr_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  cmd;
	logic [31:0] unique_id;
	logic [7:0]  node_number;
	logic        out_valid;
	logic        out_ready;
	logic        stored;
	logic        is_valid_remote;
	logic [7:0]  free_number;

	// Shadow copy of the node table and the own number.
	logic [31:0] shadow_uid [nimt_pkg::ENTRIES];
	logic [7:0]  shadow_num [nimt_pkg::ENTRIES];
	logic [7:0]  shadow_own;

	table_reply_t   awaited_replies [$];
	table_request_t survey_rows [$];

	int send_gap_pct;
	int stall_pct;
	int sent_count;
	int reply_count;
	int mismatches;
	int full_drops;
	int alloc_exhausted;
	int cycle_count;

	node_id_map_table dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cmd             (cmd),
		.unique_id       (unique_id),
		.node_number     (node_number),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.stored          (stored),
		.is_valid_remote (is_valid_remote),
		.free_number     (free_number)
	);

	// Free-running clock with a 10 ns period.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// True when any entry, empty or not, holds this number.
	function automatic bit number_taken(input int unsigned k);
		for (int i = 0; i < nimt_pkg::ENTRIES; i++)
			if (shadow_num[i] == k[7:0])
				return 1'b1;
		return 1'b0;
	endfunction

	// Applies one request to the shadow table and returns the reply it should give.
	function automatic table_reply_t next_table_reply(input nimt_pkg::cmd_t op,
			input logic [31:0] id, input logic [7:0] num);
		table_reply_t r;
		int slot;
		r = '{stored: 1'b0, valid_remote: 1'b0, free_num: 8'd0};
		slot = -1;
		case (op)
			nimt_pkg::CMD_CLEAR: begin
				for (int i = 0; i < nimt_pkg::ENTRIES; i++) begin
					shadow_uid[i] = '0;
					shadow_num[i] = '0;
				end
			end
			nimt_pkg::CMD_INSERT: begin
				// A matching ID wins; otherwise the lowest empty entry. An ID of zero
				// thus lands on the lowest empty entry and leaves it empty.
				for (int i = 0; i < nimt_pkg::ENTRIES; i++)
					if (slot < 0 && shadow_uid[i] == id)
						slot = i;
				for (int i = 0; i < nimt_pkg::ENTRIES; i++)
					if (slot < 0 && shadow_uid[i] == '0)
						slot = i;
				if (slot >= 0) begin
					shadow_uid[slot] = id;
					shadow_num[slot] = num;
					r.stored = 1'b1;
				end
			end
			nimt_pkg::CMD_QUERY: begin
				if (num != 8'd0 && num != shadow_own)
					r.valid_remote = number_taken(num);
			end
			default: begin
				// Walk downwards so that the lowest free number is the one left.
				for (int k = nimt_pkg::ENTRIES - 1; k >= 1; k--)
					if (k[7:0] != shadow_own && !number_taken(k))
						r.free_num = k[7:0];
			end
		endcase
		return r;
	endfunction

	function automatic table_request_t request_row(input nimt_pkg::cmd_t op,
			input logic [31:0] id, input logic [7:0] num);
		table_request_t q;
		q.op = op;
		q.id = id;
		q.num = num;
		q.typed = 1'b0;
		q.want = '{stored: 1'b0, valid_remote: 1'b0, free_num: 8'd0};
		return q;
	endfunction

	function automatic table_request_t known_row(input nimt_pkg::cmd_t op,
			input logic [31:0] id, input logic [7:0] num, input logic st, input logic vr,
			input logic [7:0] fr);
		table_request_t q;
		q = request_row(op, id, num);
		q.typed = 1'b1;
		q.want = '{stored: st, valid_remote: vr, free_num: fr};
		return q;
	endfunction

	// Presents one request, waits for it to be taken and records the awaited reply.
	task automatic send_request(input table_request_t q);
		table_reply_t r;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		cmd         <= q.op;
		unique_id   <= q.id;
		node_number <= q.num;
		do @(posedge clk); while (!in_ready);
		r = next_table_reply(q.op, q.id, q.num);
		if (q.op == nimt_pkg::CMD_INSERT && !r.stored)
			full_drops++;
		if (q.op == nimt_pkg::CMD_ALLOC && r.free_num == 8'd0)
			alloc_exhausted++;
		awaited_replies.push_back(q.typed ? q.want : r);
		sent_count++;
	endtask

	// Number to query: mostly small numbers, sometimes the own number or any byte.
	function automatic logic [7:0] query_number();
		case ($urandom_range(0, 3))
			0: return shadow_own;
			1: return 8'($urandom);
			default: return 8'($urandom_range(0, nimt_pkg::ENTRIES + 3));
		endcase
	endfunction

	// A clear followed by a run of inserts that often fills the table, with queries and
	// allocations mixed in. Numbers mostly count up through 1..ENTRIES-1 so that the
	// allocator can run dry.
	task automatic fill_sequence();
		logic [31:0] pool [$];
		logic [31:0] id;
		logic [7:0]  num;
		int n;
		send_request(request_row(nimt_pkg::CMD_CLEAR, $urandom, 8'($urandom)));
		n = $urandom_range(0, 1) ?
			$urandom_range(nimt_pkg::ENTRIES - 2, nimt_pkg::ENTRIES + 8)
			: $urandom_range(4, nimt_pkg::ENTRIES - 3);
		for (int i = 0; i < n; i++) begin
			if (pool.size() > 0 && $urandom_range(0, 4) == 0)
				id = pool[$urandom_range(0, pool.size() - 1)];
			else begin
				id = $urandom;
				pool.push_back(id);
			end
			case ($urandom_range(0, 9))
				0: num = 8'($urandom);
				1: num = 8'($urandom_range(0, nimt_pkg::ENTRIES + 8));
				default: num = 8'((i % (nimt_pkg::ENTRIES - 1)) + 1);
			endcase
			send_request(request_row(nimt_pkg::CMD_INSERT, id, num));
			case ($urandom_range(0, 5))
				0: send_request(request_row(nimt_pkg::CMD_QUERY, $urandom, query_number()));
				1: send_request(request_row(nimt_pkg::CMD_ALLOC, $urandom, 8'($urandom)));
				default: ;
			endcase
		end
		send_request(request_row(nimt_pkg::CMD_ALLOC, $urandom, 8'($urandom)));
		send_request(request_row(nimt_pkg::CMD_QUERY, $urandom, query_number()));
	endtask

	// Writes the own number once every awaited reply is in and the block is idle.
	task automatic set_own_number(input logic [7:0] v);
		in_valid <= 1'b0;
		while (awaited_replies.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		shadow_own   = v;
		@(posedge clk);
	endtask

	// Reply side: random back-pressure and a field-by-field check of every reply taken.
	always @(posedge clk) begin
		table_reply_t w;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				reply_count++;
				if (awaited_replies.size() == 0) begin
					if (mismatches < 10)
						$display("[%0t] unexpected reply: stored=%0b remote=%0b free=%0d",
							$realtime, stored, is_valid_remote, free_number);
					mismatches++;
				end else begin
					w = awaited_replies.pop_front();
					if (stored !== w.stored || is_valid_remote !== w.valid_remote
							|| free_number !== w.free_num) begin
						if (mismatches < 10)
							$display("[%0t] expected %0b/%0b/%0d, got %0b/%0b/%0d",
								$realtime, w.stored, w.valid_remote, w.free_num,
								stored, is_valid_remote, free_number);
						mismatches++;
					end
				end
			end
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
				awaited_replies.size());
			$display("FAILURE");
			$finish;
		end
	end

	// Main sequence: reset, directed survey, then random phases with varying idling.
	initial begin
		logic [7:0] own_values [PHASE_COUNT];
		int target;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = 8'd0;
		in_valid      = 1'b0;
		cmd           = nimt_pkg::CMD_CLEAR;
		unique_id     = '0;
		node_number   = '0;
		send_gap_pct  = 0;
		stall_pct     = 0;
		sent_count    = 0;
		reply_count   = 0;
		mismatches    = 0;
		full_drops    = 0;
		alloc_exhausted = 0;
		cycle_count   = 0;
		shadow_own    = 8'd0;
		for (int i = 0; i < nimt_pkg::ENTRIES; i++) begin
			shadow_uid[i] = '0;
			shadow_num[i] = '0;
		end
		own_values = '{8'hFF, 8'd7, 8'(nimt_pkg::ENTRIES - 1), 8'd1,
			8'($urandom_range(0, 255)), 8'd0};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed survey with the own number at its reset value of zero.
		survey_rows.push_back(known_row(nimt_pkg::CMD_ALLOC, '0, 8'd0, 1'b0, 1'b0, 8'd1));
		survey_rows.push_back(known_row(nimt_pkg::CMD_QUERY, '0, 8'd0, 1'b0, 1'b0, 8'd0));
		survey_rows.push_back(known_row(nimt_pkg::CMD_QUERY, '1, 8'hFF, 1'b0, 1'b0, 8'd0));
		survey_rows.push_back(known_row(nimt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 8'hFF,
			1'b1, 1'b0, 8'd0));
		survey_rows.push_back(known_row(nimt_pkg::CMD_QUERY, '0, 8'hFF, 1'b0, 1'b1, 8'd0));
		// An ID of zero takes the lowest empty entry but leaves it empty.
		survey_rows.push_back(known_row(nimt_pkg::CMD_INSERT, 32'h0, 8'd1,
			1'b1, 1'b0, 8'd0));
		survey_rows.push_back(request_row(nimt_pkg::CMD_ALLOC, 32'h1234_5678, 8'hA5));
		survey_rows.push_back(request_row(nimt_pkg::CMD_QUERY, '0, 8'd1));
		survey_rows.push_back(known_row(nimt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 8'd2,
			1'b1, 1'b0, 8'd0));
		survey_rows.push_back(request_row(nimt_pkg::CMD_QUERY, '0, 8'hFF));
		survey_rows.push_back(known_row(nimt_pkg::CMD_INSERT, 32'h0000_0001, 8'd0,
			1'b1, 1'b0, 8'd0));
		survey_rows.push_back(known_row(nimt_pkg::CMD_INSERT, 32'h8000_0000, 8'd3,
			1'b1, 1'b0, 8'd0));
		survey_rows.push_back(request_row(nimt_pkg::CMD_ALLOC, '1, 8'hFF));
		survey_rows.push_back(known_row(nimt_pkg::CMD_CLEAR, '1, 8'hFF, 1'b0, 1'b0, 8'd0));
		survey_rows.push_back(known_row(nimt_pkg::CMD_QUERY, '0, 8'd2, 1'b0, 1'b0, 8'd0));
		survey_rows.push_back(known_row(nimt_pkg::CMD_ALLOC, '0, 8'd0, 1'b0, 1'b0, 8'd1));
		survey_rows.push_back(known_row(nimt_pkg::CMD_INSERT, 32'hAAAA_AAAA, 8'h55,
			1'b1, 1'b0, 8'd0));
		survey_rows.push_back(known_row(nimt_pkg::CMD_INSERT, 32'h5555_5555, 8'hAA,
			1'b1, 1'b0, 8'd0));
		survey_rows.push_back(request_row(nimt_pkg::CMD_QUERY, 32'hAAAA_AAAA, 8'h55));
		survey_rows.push_back(request_row(nimt_pkg::CMD_QUERY, 32'h5555_5555, 8'hAA));
		survey_rows.push_back(known_row(nimt_pkg::CMD_INSERT, 32'h0, 8'd0,
			1'b1, 1'b0, 8'd0));
		survey_rows.push_back(request_row(nimt_pkg::CMD_ALLOC, '0, 8'd0));
		survey_rows.push_back(known_row(nimt_pkg::CMD_CLEAR, '0, 8'd0, 1'b0, 1'b0, 8'd0));
		foreach (survey_rows[i])
			send_request(survey_rows[i]);

		// Random phases: each sets a new own number and an idling pattern.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			set_own_number(own_values[p]);
			case (p % 4)
				0: begin send_gap_pct = 0;  stall_pct = 0;  end
				1: begin send_gap_pct = 60; stall_pct = 0;  end
				2: begin send_gap_pct = 0;  stall_pct = 60; end
				default: begin send_gap_pct = 22; stall_pct = 22; end
			endcase
			target = sent_count + 205;
			while (sent_count < target) begin
				if ($urandom_range(0, 99) < 70)
					fill_sequence();
				else
					repeat ($urandom_range(1, 8))
						send_request(request_row(nimt_pkg::cmd_t'($urandom_range(0, 3)),
							($urandom_range(0, 7) == 0) ? 32'h0 : 32'($urandom),
							8'($urandom)));
			end
		end

		// Drain the remaining replies, then allow a few turns of the ring.
		in_valid <= 1'b0;
		while (awaited_replies.size() != 0)
			@(posedge clk);
		repeat (2 * nimt_pkg::ENTRIES + 4) @(posedge clk);

		$display("%0d requests sent and %0d replies checked over %0d own-number settings.",
			sent_count, reply_count, PHASE_COUNT + 1);
		$display("Inserts dropped on a full table: %0d; allocations with no free number: %0d.",
			full_drops, alloc_exhausted);
		if (mismatches == 0 && awaited_replies.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d replies never arrived", mismatches,
				awaited_replies.size());
			$display("FAILURE");
		end
		$finish;
	end

endmodule
